// ===== hw/rtl/tlb_pkg.sv =====
`default_nettype none

package tlb_pkg;

	localparam int unsigned ENTRIES_DEF = 16;
	localparam int unsigned PAGE_W      = 20;
	localparam int unsigned FRAME_W     = 16;
	localparam int unsigned CNT_W       = 32;

	typedef logic [PAGE_W-1:0]  page_t;
	typedef logic [FRAME_W-1:0] frame_t;
	typedef logic [CNT_W-1:0]   cnt_t;

	typedef enum logic [0:0] {
		ACT_LOOKUP = 1'b0,
		ACT_INSERT = 1'b1
	} action_t;

	typedef struct packed {
		action_t action;
		page_t   page;
		frame_t  frame_in;
		logic    is_write;
		logic    read_only_in;
	} req_t;

	typedef struct packed {
		logic   hit;
		frame_t frame_out;
		cnt_t   hits_total;
		cnt_t   misses_total;
		cnt_t   inserts_total;
	} rsp_t;

	// scan token handed from cell to cell
	typedef struct packed {
		logic   active;
		logic   match;
		logic   match_ro;
		logic   free;
		frame_t match_frame;
	} tok_t;

	typedef enum logic [1:0] {
		TGT_MATCH = 2'd0,
		TGT_FREE  = 2'd1,
		TGT_LRU   = 2'd2
	} tgt_t;

	// update broadcast to every cell
	typedef struct packed {
		logic   en;
		logic   ins;
		tgt_t   tgt;
		page_t  page;
		frame_t frame;
		logic   ro;
	} cmd_t;

	typedef enum logic [1:0] {
		ST_IDLE   = 2'd0,
		ST_LAUNCH = 2'd1,
		ST_SCAN   = 2'd2
	} state_t;

endpackage

`default_nettype wire

// ===== hw/rtl/tlb_cell.sv =====
`default_nettype none

module tlb_cell #(
	parameter int unsigned ENTRIES = tlb_pkg::ENTRIES_DEF,
	parameter int unsigned IDX     = 0,
	localparam int unsigned RW     = $clog2(ENTRIES)
) (
	input  logic             clk,
	input  logic             arst_n,
	input  tlb_pkg::tok_t    tok_prev,
	input  logic [RW-1:0]    mrank_prev,
	input  logic [RW-1:0]    frank_prev,
	output tlb_pkg::tok_t    tok_next,
	output logic [RW-1:0]    mrank_next,
	output logic [RW-1:0]    frank_next,
	input  tlb_pkg::cmd_t    cmd,
	input  logic [RW-1:0]    cmd_rank
);

	import tlb_pkg::*;

	logic          valid_q;
	page_t         page_q;
	frame_t        frame_q;
	logic          ro_q;
	logic [RW-1:0] rank_q;
	logic          sel_m_q;
	logic          sel_f_q;
	logic          sel_l_q;

	logic hit_here;
	logic m_here;
	logic f_here;
	logic l_here;
	logic tgt_here;
	logic older;

	assign hit_here = valid_q && (page_q == cmd.page);
	assign m_here   = hit_here && !tok_prev.match;
	assign f_here   = !valid_q && !tok_prev.free;
	assign l_here   = (rank_q == RW'(ENTRIES - 1));
	assign older    = (rank_q < cmd_rank);

	always_comb begin
		unique case (cmd.tgt)
			TGT_MATCH: tgt_here = sel_m_q;
			TGT_FREE:  tgt_here = sel_f_q;
			TGT_LRU:   tgt_here = sel_l_q;
			default:   tgt_here = 1'b0;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_q  <= 1'b0;
			rank_q   <= RW'(IDX);
			sel_m_q  <= 1'b0;
			sel_f_q  <= 1'b0;
			sel_l_q  <= 1'b0;
			tok_next <= '0;
		end else begin
			tok_next.active      <= tok_prev.active;
			tok_next.match       <= tok_prev.match || hit_here;
			tok_next.match_ro    <= m_here ? ro_q : tok_prev.match_ro;
			tok_next.free        <= tok_prev.free || !valid_q;
			tok_next.match_frame <= m_here ? frame_q : tok_prev.match_frame;
			if (tok_prev.active) begin
				sel_m_q <= m_here;
				sel_f_q <= f_here;
				sel_l_q <= l_here;
			end
			if (cmd.en) begin
				if (tgt_here) begin
					rank_q <= '0;
				end else if (older) begin
					rank_q <= rank_q + 1'b1;
				end
				if (tgt_here && cmd.ins) begin
					valid_q <= 1'b1;
				end
			end
		end
	end

	always_ff @(posedge clk) begin
		mrank_next <= m_here ? rank_q : mrank_prev;
		frank_next <= f_here ? rank_q : frank_prev;
		if (cmd.en && cmd.ins && tgt_here) begin
			page_q  <= cmd.page;
			frame_q <= cmd.frame;
			ro_q    <= cmd.ro;
		end
	end

endmodule

`default_nettype wire

// ===== hw/rtl/tlb_lru_lookup_insert.sv =====
// the taken transaction is registered, then the launch state starts a scan token that
// walks the row of entry cells one cell per cycle; when it leaves the last cell the
// update is broadcast and done is registered; start is ignored while busy
// the receiver cannot stall; each result is shown for one cycle with done
// reset: all entries invalid, recency in entry index order, counters zero
`default_nettype none

module tlb_lru_lookup_insert #(
	parameter int unsigned ENTRIES = tlb_pkg::ENTRIES_DEF
) (
	input  logic          clk,
	input  logic          arst_n,
	input  logic          start,
	input  tlb_pkg::req_t req,
	output logic          busy,
	output logic          done,
	output tlb_pkg::rsp_t rsp
);

	import tlb_pkg::*;

	localparam int unsigned RW = $clog2(ENTRIES);

	state_t        state_q;
	state_t        state_d;
	req_t          req_q;
	tok_t          tok   [ENTRIES+1];
	logic [RW-1:0] mrank [ENTRIES+1];
	logic [RW-1:0] frank [ENTRIES+1];
	cmd_t          cmd;
	logic [RW-1:0] cmd_rank;
	logic          accept;
	logic          launch;
	logic          finish;
	logic          is_ins;
	logic          lookup_hit;
	logic          done_q;
	logic          hit_q;
	frame_t        frame_out_q;
	cnt_t          hits_q;
	cnt_t          misses_q;
	cnt_t          inserts_q;

	assign accept = start && !busy;
	assign finish = tok[ENTRIES].active;

	always_comb begin
		state_d = state_q;
		unique case (state_q)
			ST_IDLE:   if (accept) state_d = ST_LAUNCH;
			ST_LAUNCH: state_d = ST_SCAN;
			ST_SCAN:   if (finish) state_d = ST_IDLE;
			default:   state_d = ST_IDLE;
		endcase
	end

	always_comb begin
		unique case (state_q)
			ST_IDLE: begin
				busy   = 1'b0;
				launch = 1'b0;
			end
			ST_LAUNCH: begin
				busy   = 1'b1;
				launch = 1'b1;
			end
			default: begin
				busy   = 1'b1;
				launch = 1'b0;
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
		end else begin
			state_q <= state_d;
		end
	end

	always_ff @(posedge clk) begin
		if (accept) begin
			req_q <= req;
		end
	end

	assign tok[0]   = '{active: launch, match: 1'b0, match_ro: 1'b0, free: 1'b0,
	                    match_frame: '0};
	assign mrank[0] = '0;
	assign frank[0] = '0;

	for (genvar i = 0; i < ENTRIES; i++) begin : g_cell
		tlb_cell #(
			.ENTRIES (ENTRIES),
			.IDX     (i)
		) u_cell (
			.clk        (clk),
			.arst_n     (arst_n),
			.tok_prev   (tok[i]),
			.mrank_prev (mrank[i]),
			.frank_prev (frank[i]),
			.tok_next   (tok[i+1]),
			.mrank_next (mrank[i+1]),
			.frank_next (frank[i+1]),
			.cmd        (cmd),
			.cmd_rank   (cmd_rank)
		);
	end

	assign is_ins     = (req_q.action == ACT_INSERT);
	assign lookup_hit = !is_ins && tok[ENTRIES].match
	                    && !(req_q.is_write && tok[ENTRIES].match_ro);

	always_comb begin
		cmd.en    = finish && (is_ins || lookup_hit);
		cmd.ins   = is_ins;
		cmd.page  = req_q.page;
		cmd.frame = req_q.frame_in;
		cmd.ro    = req_q.read_only_in;
		priority if (!is_ins || tok[ENTRIES].match) begin
			cmd.tgt  = TGT_MATCH;
			cmd_rank = mrank[ENTRIES];
		end else if (tok[ENTRIES].free) begin
			cmd.tgt  = TGT_FREE;
			cmd_rank = frank[ENTRIES];
		end else begin
			cmd.tgt  = TGT_LRU;
			cmd_rank = RW'(ENTRIES - 1);
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			done_q    <= 1'b0;
			hits_q    <= '0;
			misses_q  <= '0;
			inserts_q <= '0;
		end else begin
			done_q <= finish;
			if (finish) begin
				priority if (is_ins) begin
					if (inserts_q != '1) inserts_q <= inserts_q + 1'b1;
				end else if (lookup_hit) begin
					if (hits_q != '1) hits_q <= hits_q + 1'b1;
				end else begin
					if (misses_q != '1) misses_q <= misses_q + 1'b1;
				end
			end
		end
	end

	always_ff @(posedge clk) begin
		if (finish) begin
			hit_q       <= lookup_hit;
			frame_out_q <= lookup_hit ? tok[ENTRIES].match_frame : '0;
		end
	end

	assign done = done_q;
	assign rsp  = '{hit: hit_q, frame_out: frame_out_q, hits_total: hits_q,
	               misses_total: misses_q, inserts_total: inserts_q};

	a_done_not_busy: assert property (@(posedge clk) disable iff (!arst_n)
		done |-> !busy)
		else $error("result strobe while busy");

	a_accept_busy: assert property (@(posedge clk) disable iff (!arst_n)
		accept |=> busy && state_q == ST_LAUNCH)
		else $error("accepted transaction did not launch");

	a_token_in_scan: assert property (@(posedge clk) disable iff (!arst_n)
		finish |-> state_q == ST_SCAN)
		else $error("scan token arrived outside scan");

	a_hit_lookup: assert property (@(posedge clk) disable iff (!arst_n)
		done && rsp.hit |-> req_q.action == ACT_LOOKUP)
		else $error("hit reported for insert");

endmodule

`default_nettype wire
